### rtl/assert_macros.svh
// Assertion macros for the display link driver checks.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SSLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SSLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ssld_pkg.sv
// Shared types, constants and the byte send order for the display link driver.
// No dependencies.
package ssld_pkg;

	localparam int DIGITS_DEF = 6;   // digit bytes sent per frame
	localparam int DIGITS_MAX = 8;
	localparam int IN_DIGITS  = 6;   // digit fields on the input beat
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_CTRL  = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_BRIGHTNESS = 1'b0;
	localparam logic REG_DISPLAY_ON = 1'b1;

	localparam logic [7:0] CMD_CTRL   = 8'h80;
	localparam logic [7:0] CTRL_ON    = 8'h08;
	localparam logic [7:0] CMD_DATA   = 8'h40;
	localparam logic [7:0] CMD_ADDR   = 8'hC0;
	localparam logic [2:0] BRIGHT_RST = 3'd7;

	typedef logic [7:0] seg_t;

	typedef struct packed {
		logic [2:0] brightness;
		logic       display_on;
	} cfg_t;

	typedef struct packed {
		logic clock_line;
		logic data_line;
		logic busy;
		logic done;
	} res_t;

	// digit position sent in slot k
	function automatic logic [2:0] send_pos(input int k);
		logic [2:0] pos;
		case (k)
			0: pos = 3'd2;
			1: pos = 3'd1;
			2: pos = 3'd0;
			3: pos = 3'd5;
			4: pos = 3'd4;
			5: pos = 3'd3;
			6: pos = 3'd6;
			default: pos = 3'd7;
		endcase
		return pos;
	endfunction

endpackage

### rtl/ssld_cfg.sv
// APB register block: brightness and display enable.
// Depends on ssld_pkg.
module ssld_cfg
	import ssld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	logic [2:0] brightness_q;
	logic       display_on_q;
	logic       wr_en;

	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHT_RST;
			display_on_q <= 1'b1;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BRIGHTNESS: brightness_q <= pwdata[2:0];
				REG_DISPLAY_ON: display_on_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DISPLAY_ON: prdata = {{(DATA_W-1){1'b0}}, display_on_q};
			default:        prdata = {{(DATA_W-3){1'b0}}, brightness_q};
		endcase
	end

	assign cfg.brightness = brightness_q;
	assign cfg.display_on = display_on_q;

endmodule

### rtl/ssld_seq.sv
// Link sequencer: frame store, bit shifter and phase state, one phase per tick.
// Depends on ssld_pkg.
module ssld_seq
	import ssld_pkg::*;
#(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [1:0] kind,
	input  seg_t       digits [IN_DIGITS],
	input  cfg_t       cfg,
	output res_t       res
);

	localparam int BYTE_W = $clog2(DIGITS + 1);
	localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_START_A = 8'b0000_0010,
		ST_BYTE_A  = 8'b0000_0100,
		ST_STOP_A  = 8'b0000_1000,
		ST_START_B = 8'b0001_0000,
		ST_ADDR    = 8'b0010_0000,
		ST_DATA    = 8'b0100_0000,
		ST_STOP_B  = 8'b1000_0000
	} stage_t;

	stage_t            stage_q, stage_d;
	logic [1:0]        phase_q, phase_d;
	logic [3:0]        bit_q, bit_d;
	logic [BYTE_W-1:0] byte_q, byte_d, byte_nx;
	logic              req_q, req_d;
	logic [7:0]        shift_q, shift_d;
	logic              clk_lvl_q, clk_lvl_d;
	logic              dat_lvl_q, dat_lvl_d;
	logic              busy, unit_end, done, frame_we;

	// frame held in send order, so slot k goes out k-th
	seg_t slot_q   [DIGITS];
	seg_t slot_new [DIGITS];

	for (genvar k = 0; k < DIGITS; k++) begin : g_slot
		localparam logic [2:0] POS = send_pos(k);
		if (int'(POS) < IN_DIGITS) begin : g_in
			assign slot_new[k] = digits[POS];
		end else begin : g_zero
			assign slot_new[k] = '0;
		end
	end

	assign busy    = (stage_q != ST_IDLE);
	assign byte_nx = byte_q + 1'b1;

	always_comb begin
		stage_d   = stage_q;
		phase_d   = phase_q;
		bit_d     = bit_q;
		byte_d    = byte_q;
		req_d     = req_q;
		shift_d   = shift_q;
		clk_lvl_d = clk_lvl_q;
		dat_lvl_d = dat_lvl_q;
		unit_end  = 1'b0;
		done      = 1'b0;
		frame_we  = 1'b0;

		if (step_en) begin
			case (kind)
				KIND_TICK: begin
					if (busy) begin
						case (stage_q)
							ST_START_A, ST_START_B: begin
								case (phase_q)
									2'd0: begin
										clk_lvl_d = 1'b1;
										dat_lvl_d = 1'b1;
									end
									2'd1: dat_lvl_d = 1'b0;
									default: begin
										clk_lvl_d = 1'b0;
										unit_end  = 1'b1;
									end
								endcase
							end
							ST_STOP_A, ST_STOP_B: begin
								case (phase_q)
									2'd0: begin
										clk_lvl_d = 1'b0;
										dat_lvl_d = 1'b0;
									end
									2'd1: clk_lvl_d = 1'b1;
									default: begin
										dat_lvl_d = 1'b1;
										unit_end  = 1'b1;
									end
								endcase
							end
							default: begin
								if (!bit_q[3]) begin
									// data bit, LSB first
									case (phase_q)
										2'd0: clk_lvl_d = 1'b0;
										2'd1: dat_lvl_d = shift_q[0];
										default: begin
											clk_lvl_d = 1'b1;
											shift_d   = {1'b0, shift_q[7:1]};
											bit_d     = bit_q + 4'd1;
										end
									endcase
								end else begin
									// acknowledge slot, driven low
									case (phase_q)
										2'd0: begin
											clk_lvl_d = 1'b0;
											dat_lvl_d = 1'b0;
										end
										2'd1: clk_lvl_d = 1'b1;
										default: begin
											clk_lvl_d = 1'b0;
											unit_end  = 1'b1;
										end
									endcase
								end
							end
						endcase

						phase_d = phase_q[1] ? 2'd0 : phase_q + 2'd1;

						if (unit_end) begin
							bit_d = '0;
							case (stage_q)
								ST_START_A: stage_d = ST_BYTE_A;
								ST_BYTE_A:  stage_d = ST_STOP_A;
								ST_STOP_A: begin
									if (req_q) begin
										stage_d = ST_START_B;
									end else begin
										stage_d = ST_IDLE;
										done    = 1'b1;
									end
								end
								ST_START_B: begin
									stage_d = ST_ADDR;
									shift_d = CMD_ADDR;
								end
								ST_ADDR: begin
									stage_d = ST_DATA;
									byte_d  = '0;
									shift_d = slot_q[0];
								end
								ST_DATA: begin
									byte_d = byte_nx;
									if (byte_nx < BYTE_W'(DIGITS)) begin
										shift_d = slot_q[byte_nx[IDX_W-1:0]];
									end else begin
										stage_d = ST_STOP_B;
									end
								end
								default: begin
									stage_d = ST_IDLE;
									done    = 1'b1;
								end
							endcase
						end
					end
				end
				KIND_CTRL: begin
					if (!busy) begin
						req_d   = 1'b0;
						shift_d = CMD_CTRL | (cfg.display_on ? CTRL_ON : 8'h00)
							| {5'd0, cfg.brightness};
						phase_d = '0;
						bit_d   = '0;
						byte_d  = '0;
						stage_d = ST_START_A;
					end
				end
				KIND_FRAME: begin
					if (!busy) begin
						frame_we = 1'b1;
						req_d    = 1'b1;
						shift_d  = CMD_DATA;
						phase_d  = '0;
						bit_d    = '0;
						byte_d   = '0;
						stage_d  = ST_START_A;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= ST_IDLE;
			phase_q   <= '0;
			bit_q     <= '0;
			byte_q    <= '0;
			req_q     <= 1'b0;
			shift_q   <= '0;
			clk_lvl_q <= 1'b1;
			dat_lvl_q <= 1'b1;
		end else begin
			stage_q   <= stage_d;
			phase_q   <= phase_d;
			bit_q     <= bit_d;
			byte_q    <= byte_d;
			req_q     <= req_d;
			shift_q   <= shift_d;
			clk_lvl_q <= clk_lvl_d;
			dat_lvl_q <= dat_lvl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_we) begin
			for (int k = 0; k < DIGITS; k++) begin
				slot_q[k] <= slot_new[k];
			end
		end
	end

	assign res.clock_line = clk_lvl_d;
	assign res.data_line  = dat_lvl_d;
	assign res.busy       = (stage_d != ST_IDLE);
	assign res.done       = done;

endmodule

### rtl/seven_segment_serial_link_driver.sv
// Two-wire LED display link driver: one pin-level phase per tick beat.
// A beat passes through the input register stage and then the result register,
// where out_valid marks its result. Throughput: one beat per cycle unless the output
// is stalled; each beat is one pass of the phase sequencer.
// Reset (arst_n low, async): pipeline empty, sequencer idle with its pin levels high,
// brightness 7, display enabled.
module seven_segment_serial_link_driver
	import ssld_pkg::*;
#(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input beats
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        digit_0,
	input  logic [7:0]        digit_1,
	input  logic [7:0]        digit_2,
	input  logic [7:0]        digit_3,
	input  logic [7:0]        digit_4,
	input  logic [7:0]        digit_5,
	// result beats
	output logic              out_valid,
	input  logic              out_stall,
	output logic              clock_line,
	output logic              data_line,
	output logic              busy_res,
	output logic              transfer_done,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Input register stage
	logic       valid_s1;
	logic [1:0] kind_s1;
	seg_t       digit_s1 [IN_DIGITS];

	// Result register stage
	logic valid_s2;
	res_t res_s2;

	cfg_t cfg;
	res_t res_nx;
	logic adv;       // stage 1 may hand its beat on
	logic in_take;

	// Result slot frees when empty or being taken this cycle.
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1     <= kind;
			digit_s1[0] <= digit_0;
			digit_s1[1] <= digit_1;
			digit_s1[2] <= digit_2;
			digit_s1[3] <= digit_3;
			digit_s1[4] <= digit_4;
			digit_s1[5] <= digit_5;
		end
	end

	ssld_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Sequencer state moves only when a beat passes into the result register.
	ssld_seq #(
		.DIGITS (DIGITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (valid_s1 && adv),
		.kind    (kind_s1),
		.digits  (digit_s1),
		.cfg     (cfg),
		.res     (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2 <= res_nx;
		end
	end

	assign out_valid     = valid_s2;
	assign clock_line    = res_s2.clock_line;
	assign data_line     = res_s2.data_line;
	assign busy_res      = res_s2.busy;
	assign transfer_done = res_s2.done;

endmodule

### rtl/ssld_checker.sv
// Port-level checks for the display link driver, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssld_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic clock_line,
	input logic data_line,
	input logic busy_res,
	input logic transfer_done
);

	// held result beat does not change
	`SSLD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable({clock_line, data_line, busy_res, transfer_done}), "result beat changed while stalled")

	// a finished request leaves the link idle
	`SSLD_ASSERT(a_done_idle, out_valid && transfer_done |-> !busy_res, "transfer_done while still busy")

	// idle link rests with both lines high
	`SSLD_ASSERT(a_idle_lines, out_valid && !busy_res |-> clock_line && data_line, "idle link not at rest levels")

endmodule

bind seven_segment_serial_link_driver ssld_checker u_ssld_checker (.*);
